[rtl/core/sustain_compressor_gate_macros.svh]
// Assertion macros shared by the sustain compressor/gate RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef SUSTAIN_COMPRESSOR_GATE_MACROS_SVH
`define SUSTAIN_COMPRESSOR_GATE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SCG_ASSERT_IMPL(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SCG_ASSERT_NEXT(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/scg_pkg.sv]
// Package for the sustain compressor/gate: constants, register indexes,
// controller/datapath command and status types. No dependencies.
package scg_pkg;

  localparam int SCG_SAMPLE_BITS = 24;

  localparam int WEIGHT_W  = 9;
  localparam int CFG_IDX_W = 2;

  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX     = 9'd256;
  localparam logic [WEIGHT_W-1:0] NOISE_RESET    = 9'd40;
  localparam logic [WEIGHT_W-1:0] SUSTAIN_RESET  = 9'd256;
  localparam logic [WEIGHT_W-1:0] GATE_RESET     = 9'd256;
  localparam logic [WEIGHT_W-1:0] GATE_OFF_MAX   = 9'd1;

  localparam logic [14:0] GAIN_NUM = 15'd30000;
  localparam logic [6:0]  MIX_DEN  = 7'd100;

  // Gain is Q8.16, gate is Q1.16 so that 1.0 is representable.
  localparam int Q_BITS    = 24;
  localparam int FRAC_BITS = 16;
  localparam int LOW_BITS  = Q_BITS - FRAC_BITS;
  localparam int GATE_W    = FRAC_BITS + 1;
  localparam int TLO_W     = 32;

  localparam logic [Q_BITS-1:0] GAIN_MAX = {Q_BITS{1'b1}};
  localparam logic [GATE_W-1:0] ONE_Q16  = GATE_W'(1) << FRAC_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NOISE_WEIGHT   = 2'd0,
    REG_SUSTAIN_WEIGHT = 2'd1,
    REG_GATE_WEIGHT    = 2'd2
  } scg_reg_e;

  typedef struct packed {
    logic capture;
    logic env_a;
    logic env_b;
    logic gain_a;
    logic gain_b;
    logic gain_chk;
    logic gain_take;
    logic gate_chk;
    logic gate_take;
    logic div_start;
    logic div_gate;
    logic mul_a;
    logic mul_b;
    logic mul_c;
    logic out_load;
  } scg_cmd_t;

  typedef struct packed {
    logic gain_direct;
    logic gate_direct;
    logic div_done;
    logic out_free;
  } scg_stat_t;

  function automatic logic [WEIGHT_W-1:0] sat_weight(input logic [WEIGHT_W-1:0] w);
    sat_weight = (w > WEIGHT_MAX) ? WEIGHT_MAX : w;
  endfunction

endpackage

[rtl/core/scg_if.sv]
// Stream interfaces for sample input and output channels.
// Depends on scg_pkg for the default sample width.
interface scg_in_if import scg_pkg::*; #(parameter int SAMPLE_BITS = SCG_SAMPLE_BITS);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic                          end_of_block;

  modport source (output valid, output sample_in, output end_of_block, input ready);
  modport sink   (input valid, input sample_in, input end_of_block, output ready);
endinterface

interface scg_out_if import scg_pkg::*; #(parameter int SAMPLE_BITS = SCG_SAMPLE_BITS);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          end_of_block_out;

  modport source (output valid, output sample_out, output end_of_block_out, input ready);
  modport sink   (input valid, input sample_out, input end_of_block_out, output ready);
endinterface

[rtl/core/sustain_compressor_gate.sv]
// Top level of the sustain compressor with noise gate.
// Depends on scg_pkg, scg_if, scg_ctrl and scg_datapath.

// One sample is processed at a time. After a sample transfers in, its result is
// ready sooner when neither gain nor gate needs a division than when both do; each
// division runs on one shared restoring divider that produces one of 24 quotient
// bits per cycle, and that divider sets the rate whenever a division is needed.
// The result sits in an output register, so the next sample transfers in the
// cycle after the result is loaded even if the downstream side has not taken it.
// Weight registers may be written only while no sample is in flight.
module sustain_compressor_gate import scg_pkg::*; #(
  parameter int SAMPLE_BITS = SCG_SAMPLE_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WEIGHT_W-1:0]  cfg_data,
  scg_in_if.sink               din,
  scg_out_if.source            dout
);

  scg_cmd_t  cmd;
  scg_stat_t stat;
  logic      in_ready;

  assign din.ready = in_ready;

  scg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (din.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  scg_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_sample  (din.sample_in),
    .in_eob     (din.end_of_block),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (dout.valid),
    .out_ready  (dout.ready),
    .out_sample (dout.sample_out),
    .out_eob    (dout.end_of_block_out)
  );

endmodule

[rtl/core/scg_div.sv]
// Restoring divider, one quotient bit per cycle: floor({rem_init, low_init, 0^16} / divisor).
// Depends on scg_pkg and the assertion macro header.
`include "sustain_compressor_gate_macros.svh"

module scg_div import scg_pkg::*; #(
  parameter int DIV_W = SCG_SAMPLE_BITS + 7
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [DIV_W-1:0]    rem_init,
  input  logic [LOW_BITS-1:0] low_init,
  input  logic [DIV_W-1:0]    divisor,
  output logic [Q_BITS-1:0]   quo,
  output logic                done
);

  localparam int CNT_W = $clog2(Q_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(Q_BITS - 1);

  logic [DIV_W-1:0]  rem;
  logic [Q_BITS-1:0] low;
  logic [DIV_W-1:0]  dvs;
  logic [CNT_W-1:0]  cnt;
  logic              busy;

  logic [DIV_W:0] trial;
  logic [DIV_W:0] diff;
  logic           ge;

  assign trial = {rem, low[Q_BITS-1]};
  assign ge    = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_LAST) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= rem_init;
      low <= {low_init, {FRAC_BITS{1'b0}}};
      dvs <= divisor;
      quo <= '0;
    end else if (busy) begin
      rem <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      low <= {low[Q_BITS-2:0], 1'b0};
      quo <= {quo[Q_BITS-2:0], ge};
    end
  end

  `SCG_ASSERT_IMPL(a_div_no_restart, clk, rst, start, !busy, "divider started while busy")
  `SCG_ASSERT_NEXT(a_div_finish, clk, rst, busy && !start && cnt == CNT_LAST, done && !busy,
    "divider did not finish after last step")
  `SCG_ASSERT_IMPL(a_div_done_idle, clk, rst, done, !busy, "divider done while busy")

endmodule

[rtl/core/scg_datapath.sv]
// Datapath: weight registers, envelope follower, gain/gate arithmetic, output register.
// Depends on scg_pkg and scg_div.
module scg_datapath import scg_pkg::*; #(
  parameter int SAMPLE_BITS = SCG_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [WEIGHT_W-1:0]           cfg_data,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_eob,
  input  scg_cmd_t                      cmd,
  output scg_stat_t                     stat,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_sample,
  output logic                          out_eob
);

  localparam int N     = SAMPLE_BITS;
  localparam int ACC_W = N + 9;
  localparam int A_W   = N + 11;
  localparam int DIV_W = N + 7;
  localparam int CMP_W = DIV_W + LOW_BITS;
  localparam int T_W   = N + Q_BITS;
  localparam int P_W   = TLO_W + GATE_W;
  localparam int RES_W = N + 10;

  localparam logic [RES_W-1:0] HALF    = RES_W'(1) << (N - 1);
  localparam logic [RES_W-1:0] POS_LIM = HALF - RES_W'(1);

  logic [WEIGHT_W-1:0] noise_weight;
  logic [WEIGHT_W-1:0] sustain_weight;
  logic [WEIGHT_W-1:0] gate_weight;
  logic [WEIGHT_W-1:0] nw;
  logic [WEIGHT_W-1:0] sw;
  logic [WEIGHT_W-1:0] gw;
  logic [WEIGHT_W-1:0] inv_nw;

  logic [N-1:0]        envelope;
  logic [N-1:0]        mag;
  logic                neg;
  logic                eob;
  logic [ACC_W-1:0]    acc;
  logic signed [A_W-1:0] a;
  logic [DIV_W-1:0]    den;
  logic [Q_BITS-1:0]   gain;
  logic [GATE_W-1:0]   gate;
  logic [T_W-1:0]      t;
  logic [P_W-1:0]      p_lo;
  logic [RES_W-1:0]    res;

  logic [N-1:0]          raw;
  logic [N-1:0]          mag_in;
  logic [ACC_W-1:0]      env_sum;
  logic signed [WEIGHT_W:0] sw_diff;
  logic signed [A_W-1:0] mix_prod;
  logic [CMP_W-1:0]      a_u;
  logic [CMP_W-1:0]      den_sh;
  logic                  a_pos;
  logic                  env_zero;
  logic [DIV_W-1:0]      thr;
  logic [DIV_W-1:0]      div_rem;
  logic [LOW_BITS-1:0]   div_low;
  logic [DIV_W-1:0]      div_den;
  logic [Q_BITS-1:0]     quo;
  logic                  div_done;
  logic [RES_W-1:0]      lim;
  logic [RES_W-1:0]      res_sat;
  logic [N-1:0]          res_mag;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      noise_weight   <= NOISE_RESET;
      sustain_weight <= SUSTAIN_RESET;
      gate_weight    <= GATE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NOISE_WEIGHT:   noise_weight   <= cfg_data;
        REG_SUSTAIN_WEIGHT: sustain_weight <= cfg_data;
        REG_GATE_WEIGHT:    gate_weight    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign nw     = sat_weight(noise_weight);
  assign sw     = sat_weight(sustain_weight);
  assign gw     = sat_weight(gate_weight);
  assign inv_nw = WEIGHT_MAX - nw;

  // most negative sample gives magnitude 2^(N-1), still fits N bits unsigned
  assign raw    = in_sample;
  assign mag_in = raw[N-1] ? N'(~raw + 1'b1) : raw;

  assign env_sum  = acc + ACC_W'(nw) * ACC_W'(mag);
  assign sw_diff  = $signed({3'b000, MIX_DEN}) - $signed({1'b0, sw});
  assign mix_prod = A_W'(sw_diff) * A_W'($signed({1'b0, envelope}));

  assign a_pos    = !a[A_W-1] && (a != '0);
  assign a_u      = CMP_W'($unsigned(a));
  assign den_sh   = {den, {LOW_BITS{1'b0}}};
  assign env_zero = (envelope == '0);
  assign thr      = DIV_W'(gw) * DIV_W'(MIX_DEN);

  // quotient would exceed 24 bits when a >= den * 256
  assign stat.gain_direct = env_zero || !a_pos || (a_u >= den_sh);
  assign stat.gate_direct = (gw <= GATE_OFF_MAX) || (DIV_W'(envelope) > thr);
  assign stat.div_done    = div_done;
  assign stat.out_free    = !out_valid || out_ready;

  assign div_rem = cmd.div_gate ? DIV_W'(envelope >> LOW_BITS) : a_u[CMP_W-1:LOW_BITS];
  assign div_low = cmd.div_gate ? envelope[LOW_BITS-1:0] : a_u[LOW_BITS-1:0];
  assign div_den = cmd.div_gate ? thr : den;

  scg_div #(
    .DIV_W (DIV_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .rem_init (div_rem),
    .low_init (div_low),
    .divisor  (div_den),
    .quo      (quo),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      envelope <= '0;
    end else if (cmd.env_b) begin
      envelope <= env_sum[N+7:8];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mag <= mag_in;
      neg <= raw[N-1];
      eob <= in_eob;
    end
    if (cmd.env_a) begin
      acc <= ACC_W'(inv_nw) * ACC_W'(envelope);
    end
    if (cmd.gain_a) begin
      a   <= A_W'(sw) * A_W'(GAIN_NUM);
      den <= DIV_W'(envelope) * DIV_W'(MIX_DEN);
    end
    if (cmd.gain_b) begin
      a <= a + mix_prod;
    end
    if (cmd.gain_chk && stat.gain_direct) begin
      gain <= (!env_zero && !a_pos) ? '0 : GAIN_MAX;
    end
    if (cmd.gain_take) begin
      gain <= quo;
    end
    if (cmd.gate_chk && stat.gate_direct) begin
      gate <= ONE_Q16;
    end
    if (cmd.gate_take) begin
      gate <= quo[GATE_W-1:0];
    end
    if (cmd.mul_a) begin
      t <= T_W'(mag) * T_W'(gain);
    end
    if (cmd.mul_b) begin
      p_lo <= P_W'(t[TLO_W-1:0]) * P_W'(gate);
    end
    if (cmd.mul_c) begin
      res <= RES_W'(t[T_W-1:TLO_W]) * RES_W'(gate) + RES_W'(p_lo[P_W-1:TLO_W]);
    end
  end

  // saturate magnitude, then restore sign
  assign lim     = neg ? HALF : POS_LIM;
  assign res_sat = (res > lim) ? lim : res;
  assign res_mag = res_sat[N-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_sample <= neg ? N'(~res_mag + 1'b1) : res_mag;
      out_eob    <= eob;
    end
  end

endmodule

[rtl/core/scg_ctrl.sv]
// Sequencing state machine for the sustain compressor/gate datapath.
// Depends on scg_pkg and the assertion macro header.
`include "sustain_compressor_gate_macros.svh"

module scg_ctrl import scg_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  scg_stat_t stat,
  output scg_cmd_t  cmd
);

  typedef enum logic [12:0] {
    S_IDLE     = 13'h0001,
    S_ENV_A    = 13'h0002,
    S_ENV_B    = 13'h0004,
    S_GAIN_A   = 13'h0008,
    S_GAIN_B   = 13'h0010,
    S_GAIN_CHK = 13'h0020,
    S_GAIN_DIV = 13'h0040,
    S_GATE_CHK = 13'h0080,
    S_GATE_DIV = 13'h0100,
    S_MUL_A    = 13'h0200,
    S_MUL_B    = 13'h0400,
    S_MUL_C    = 13'h0800,
    S_DONE     = 13'h1000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // no transfer is taken while reset is held
  assign in_ready = (state == S_IDLE) && !rst;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_ENV_A;
        end
      end
      S_ENV_A: begin
        cmd.env_a  = 1'b1;
        state_next = S_ENV_B;
      end
      S_ENV_B: begin
        cmd.env_b  = 1'b1;
        state_next = S_GAIN_A;
      end
      S_GAIN_A: begin
        cmd.gain_a = 1'b1;
        state_next = S_GAIN_B;
      end
      S_GAIN_B: begin
        cmd.gain_b = 1'b1;
        state_next = S_GAIN_CHK;
      end
      S_GAIN_CHK: begin
        cmd.gain_chk = 1'b1;
        if (stat.gain_direct) begin
          state_next = S_GATE_CHK;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_GAIN_DIV;
        end
      end
      S_GAIN_DIV: begin
        if (stat.div_done) begin
          cmd.gain_take = 1'b1;
          state_next    = S_GATE_CHK;
        end
      end
      S_GATE_CHK: begin
        cmd.gate_chk = 1'b1;
        if (stat.gate_direct) begin
          state_next = S_MUL_A;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_gate  = 1'b1;
          state_next    = S_GATE_DIV;
        end
      end
      S_GATE_DIV: begin
        if (stat.div_done) begin
          cmd.gate_take = 1'b1;
          state_next    = S_MUL_A;
        end
      end
      S_MUL_A: begin
        cmd.mul_a  = 1'b1;
        state_next = S_MUL_B;
      end
      S_MUL_B: begin
        cmd.mul_b  = 1'b1;
        state_next = S_MUL_C;
      end
      S_MUL_C: begin
        cmd.mul_c  = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `SCG_ASSERT_NEXT(a_ctrl_gain_wait, clk, rst, state == S_GAIN_DIV && !stat.div_done,
    state == S_GAIN_DIV, "left gain division before quotient ready")
  `SCG_ASSERT_NEXT(a_ctrl_out_hold, clk, rst, state == S_DONE && !stat.out_free,
    state == S_DONE, "result loaded over an untaken result")
  `SCG_ASSERT_IMPL(a_ctrl_load_free, clk, rst, cmd.out_load, stat.out_free,
    "output register loaded while occupied")

endmodule

[bench/tb.sv]
// Self-checking bench for sustain_compressor_gate: a directed table, then random audio-like
// blocks under several weight settings, each result checked against the table or an in-bench model.
// Depends on scg_pkg, scg_in_if/scg_out_if and the sustain_compressor_gate RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import scg_pkg::*;

  localparam int SAMPLE_BITS = SCG_SAMPLE_BITS;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;  // decodes to no register
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 85;
  localparam int MAX_GAP = 10;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 64;  // worst case: gain and gate both divide
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS = 100;
  localparam int DIR_ROWS = 23;
  localparam logic [63:0] GAIN_CEIL = 64'hFF_FFFF;
  localparam logic [63:0] UNITY_Q16 = 64'd65536;
  localparam logic [63:0] SAT_LIMIT = 64'd1 << (SAMPLE_BITS - 1);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct {
    sample_t sample;
    logic    eob;
  } result_t;

  typedef struct {
    logic [WEIGHT_W-1:0] noise;
    logic [WEIGHT_W-1:0] sustain;
    logic [WEIGHT_W-1:0] gate;
  } weights_t;

  typedef struct {
    int      phase;
    sample_t sample;
    logic    eob;
    bit      known;
    sample_t want;
  } dir_row_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WEIGHT_W-1:0]  cfg_data;

  scg_in_if  din ();
  scg_out_if dout ();

  sustain_compressor_gate dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .din       (din),
    .dout      (dout)
  );

  // model state
  logic [SAMPLE_BITS-1:0] env_track;
  logic [WEIGHT_W-1:0]    nw_cur;
  logic [WEIGHT_W-1:0]    sw_cur;
  logic [WEIGHT_W-1:0]    gw_cur;

  result_t     due_results [$];
  int          errors;
  int          checked;
  int          sent;
  int          block_ends;
  int          settings;
  bit          src_idle;
  bit          sink_idle;
  int unsigned hold_reqs;
  int unsigned hold_seen;
  int unsigned out_stall;
  int unsigned quiet;

  // phase 0: reset weights; 1: envelope = |x|, no compression, gate off, so out = in;
  // 2: frozen zero envelope, gain at ceiling; 3: every weight above 256
  weights_t dir_weights [4] = '{
    '{NOISE_RESET, SUSTAIN_RESET, GATE_RESET},
    '{9'd256, 9'd0, 9'd0},
    '{9'd0, 9'd100, 9'd1},
    '{9'd511, 9'd300, 9'd257}
  };

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{0, 24'h000000, 1'b0, 1'b1, 24'h000000},  // zero envelope, gate closed
    '{0, 24'h7FFFFF, 1'b1, 1'b1, 24'h000000},  // gain goes negative, clamped
    '{0, 24'h800000, 1'b0, 1'b1, 24'h000000},
    '{0, 24'h000001, 1'b1, 1'b0, 24'h000000},
    '{1, 24'h7FFFFF, 1'b0, 1'b1, 24'h7FFFFF},
    '{1, 24'h800000, 1'b1, 1'b1, 24'h800000},
    '{1, 24'hFFFFFF, 1'b0, 1'b1, 24'hFFFFFF},
    '{1, 24'h000001, 1'b0, 1'b1, 24'h000001},
    '{1, 24'h555555, 1'b1, 1'b1, 24'h555555},
    '{1, 24'hAAAAAA, 1'b0, 1'b1, 24'hAAAAAA},
    '{1, 24'h000000, 1'b1, 1'b1, 24'h000000},
    '{2, 24'h000001, 1'b0, 1'b1, 24'h0000FF},
    '{2, 24'hFFFFFF, 1'b1, 1'b1, 24'hFFFF01},
    '{2, 24'h000100, 1'b0, 1'b1, 24'h00FFFF},
    '{2, 24'h7FFFFF, 1'b0, 1'b1, 24'h7FFFFF},  // saturates
    '{2, 24'h800000, 1'b1, 1'b1, 24'h800000},
    '{2, 24'h008000, 1'b0, 1'b1, 24'h7FFFFF},
    '{3, 24'h000064, 1'b0, 1'b0, 24'h000000},
    '{3, 24'h004E20, 1'b1, 1'b0, 24'h000000},
    '{3, 24'hFF8AD0, 1'b0, 1'b0, 24'h000000},
    '{3, 24'h001388, 1'b0, 1'b0, 24'h000000},
    '{3, 24'h7FFFFF, 1'b1, 1'b0, 24'h000000},
    '{3, 24'hFFFFFE, 1'b0, 1'b0, 24'h000000}
  };

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Advances the envelope and returns the processed sample.
  function automatic result_t compress_sample(input sample_t x, input logic eob);
    logic [63:0] mag, nw, sw, gw, gain, gate, t, res;
    longint      num;
    result_t     r;
    mag = (x < 0) ? 64'(-longint'(x)) : 64'(longint'(x));
    nw = (nw_cur > WEIGHT_MAX) ? 64'(WEIGHT_MAX) : 64'(nw_cur);
    sw = (sw_cur > WEIGHT_MAX) ? 64'(WEIGHT_MAX) : 64'(sw_cur);
    gw = (gw_cur > WEIGHT_MAX) ? 64'(WEIGHT_MAX) : 64'(gw_cur);
    env_track = SAMPLE_BITS'(((64'd256 - nw) * env_track + nw * mag) / 64'd256);
    if (env_track == 0) begin
      gain = GAIN_CEIL;
    end else begin
      num = longint'(sw) * 30000 * 65536
          + (100 - longint'(sw)) * 65536 * longint'(env_track);
      if (num <= 0) gain = 0;  // unsigned gain cannot go below zero
      else gain = 64'(num / (100 * longint'(env_track)));
      if (gain > GAIN_CEIL) gain = GAIN_CEIL;
    end
    if (gw <= 1 || env_track > gw * 100) gate = UNITY_Q16;
    else gate = (env_track * UNITY_Q16) / (gw * 100);
    t = mag * gain;
    res = ((t >> 16) * gate + ((t[15:0] * gate) >> 16)) >> 16;
    if (x < 0) begin
      if (res > SAT_LIMIT) res = SAT_LIMIT;
      r.sample = sample_t'(-longint'(res));
    end else begin
      if (res > SAT_LIMIT - 1) res = SAT_LIMIT - 1;
      r.sample = sample_t'(res);
    end
    r.eob = eob;
    return r;
  endfunction

  function automatic logic [WEIGHT_W-1:0] pick_weight();
    logic [WEIGHT_W-1:0] corner_w [10] = '{0, 1, 2, 99, 100, 101, 255, 256, 257, 511};
    if ($urandom_range(0, 1) == 0) return corner_w[$urandom_range(0, 9)];
    return WEIGHT_W'($urandom_range(0, 511));
  endfunction

  function automatic void check_result(input sample_t got, input logic got_eob);
    result_t want;
    checked++;
    if (due_results.size() == 0) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: result with no sample pending: sample_out=%0d end_of_block_out=%b",
                 $time, got, got_eob);
      return;
    end
    want = due_results.pop_front();
    if (got !== want.sample) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: sample_out expected %0d, actual %0d", $time, want.sample, got);
    end
    if (got_eob !== want.eob) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: end_of_block_out expected %b, actual %b", $time, want.eob, got_eob);
    end
  endfunction

  // Stops offering samples and waits out every pending result.
  task automatic drain_results();
    din.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_weights(input weights_t w, input bit poke_spare);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= REG_NOISE_WEIGHT;
    cfg_data  <= w.noise;
    @(posedge clk);
    cfg_index <= REG_SUSTAIN_WEIGHT;
    cfg_data  <= w.sustain;
    @(posedge clk);
    cfg_index <= REG_GATE_WEIGHT;
    cfg_data  <= w.gate;
    @(posedge clk);
    if (poke_spare) begin
      cfg_index <= REG_SPARE;
      cfg_data  <= ~w.gate;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    nw_cur = w.noise;
    sw_cur = w.sustain;
    gw_cur = w.gate;
    settings++;
  endtask

  // Returns at the edge of the transfer; valid stays up for a back-to-back follower.
  task automatic send_sample(input sample_t s, input logic eob, input bit known,
                             input sample_t want);
    int unsigned gap;
    result_t     r;
    gap = src_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      din.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    din.valid        <= 1'b1;
    din.sample_in    <= s;
    din.end_of_block <= eob;
    do @(posedge clk); while (!din.ready);
    r = compress_sample(s, eob);
    if (known) r.sample = want;
    due_results.push_back(r);
    sent++;
    if (eob) block_ends++;
  endtask

  // Result side: random stall per transfer, plus one long hold on request.
  always @(posedge clk) begin
    int unsigned stall;
    if (rst) begin
      dout.ready <= 1'b0;
      out_stall  <= 0;
      hold_seen  <= 0;
    end else begin
      stall = out_stall;
      if (dout.valid && dout.ready) begin
        check_result(dout.sample_out, dout.end_of_block_out);
        stall = sink_idle ? $urandom_range(0, MAX_GAP) : 0;
      end
      if (hold_seen != hold_reqs) begin
        hold_seen <= hold_reqs;
        stall = HOLD_CYCLES;
      end
      dout.ready <= (stall == 0);
      out_stall  <= (stall == 0) ? 0 : stall - 1;
    end
  end

  always @(posedge clk) begin
    if (rst || (din.valid && din.ready) || (dout.valid && dout.ready)) begin
      quiet <= 0;
    end else if (quiet == WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, quiet, due_results.size());
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    weights_t    w;
    sample_t     s;
    int unsigned shift;
    int unsigned run;
    int          cur_phase;
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = REG_NOISE_WEIGHT;
    cfg_data         = '0;
    din.valid        = 1'b0;
    din.sample_in    = '0;
    din.end_of_block = 1'b0;
    dout.ready       = 1'b0;
    hold_reqs        = 0;
    src_idle         = 1'b1;
    sink_idle        = 1'b1;
    errors           = 0;
    checked          = 0;
    sent             = 0;
    block_ends       = 0;
    settings         = 1;
    env_track        = '0;
    nw_cur           = NOISE_RESET;
    sw_cur           = SUSTAIN_RESET;
    gw_cur           = GATE_RESET;
    cur_phase        = 0;
    shift            = 8;
    run              = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_rows[i].phase != cur_phase) begin
        cur_phase = dir_rows[i].phase;
        load_weights(dir_weights[cur_phase], cur_phase == 3);
      end
      send_sample(dir_rows[i].sample, dir_rows[i].eob, dir_rows[i].known, dir_rows[i].want);
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      w.noise   = pick_weight();
      w.sustain = pick_weight();
      w.gate    = pick_weight();
      load_weights(w, 1'b0);
      src_idle  = ($urandom_range(0, 3) != 0);
      sink_idle <= ($urandom_range(0, 3) != 0);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // blocks of 1..32 samples, each at one level from full scale down to +-1
        if (run == 0) begin
          run   = $urandom_range(1, 32);
          shift = $urandom_range(8, 31);
        end
        run--;
        if ($urandom_range(0, 15) == 0) begin
          case ($urandom_range(0, 4))
            0:       s = 24'h7FFFFF;
            1:       s = 24'h800000;
            2:       s = 24'h000000;
            3:       s = 24'hFFFFFF;
            default: s = 24'h000001;
          endcase
        end else begin
          s = sample_t'($signed($urandom) >>> shift);
        end
        if (p == 2 && i == 20) hold_reqs <= hold_reqs + 1;  // fill up, stall the input
        if (p == 5 && i == 40) drain_results();
        send_sample(s, run == 0, 1'b0, '0);
      end
    end

    drain_results();
    $display("Sent %0d samples (%0d block ends) over %0d weight settings, %0d results compared.",
             sent, block_ends, settings, checked);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
